### rtl/top_k_farthest_list_core_assert.svh
// Assertion macros for the checker file of the top-k farthest list.
`ifndef TOP_K_FARTHEST_LIST_CORE_ASSERT_SVH
`define TOP_K_FARTHEST_LIST_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define TKFL_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define TKFL_ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/tkfl_pkg.sv
// Types and constants of the top-k farthest list.
package tkfl_pkg;

   localparam int DIST_BITS = 32;
   localparam int KCFG_BITS = 5;
   localparam int K_RESET   = 8;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_READ   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_PRUNE,
      BK_READ
   } back_state_type;

endpackage

### rtl/tkfl_ifs.sv
// Channel interfaces of the top-k farthest list: request, response and k register write.
interface tkfl_req_if #(parameter int ID_BITS = 24) ();
   logic                           valid;
   logic                           ready;
   logic                           operation;
   logic [ID_BITS-1:0]             cand_id;
   logic [tkfl_pkg::DIST_BITS-1:0] cand_dist;

   modport source (output valid, operation, cand_id, cand_dist, input ready);
   modport sink (input valid, operation, cand_id, cand_dist, output ready);
endinterface

interface tkfl_rsp_if #(parameter int ID_BITS = 24) ();
   logic                           valid;
   logic                           ready;
   logic                           prune_valid;
   logic [tkfl_pkg::DIST_BITS-1:0] prune_dist;
   logic                           entry_valid;
   logic [ID_BITS-1:0]             entry_id;
   logic [tkfl_pkg::DIST_BITS-1:0] entry_dist;
   logic                           last;

   modport source (output valid, prune_valid, prune_dist, entry_valid, entry_id, entry_dist,
                   last, input ready);
   modport sink (input valid, prune_valid, prune_dist, entry_valid, entry_id, entry_dist,
                 last, output ready);
endinterface

interface tkfl_csr_if ();
   logic                           valid;
   logic                           ready;
   logic [tkfl_pkg::KCFG_BITS-1:0] k_count;

   modport source (output valid, k_count, input ready);
   modport sink (input valid, k_count, output ready);
endinterface

### rtl/tkfl_front.sv
// Front end: accepts request words, decodes the operation and queues them for the list.
module tkfl_front #(
   parameter int ID_BITS = 24
) (
   input logic          clock,
   input logic          reset,
   tkfl_req_if.sink     req,
   tkfl_req_if.source   q
);

   localparam logic [1:0] FILL_FULL = 2'd2;

   tkfl_pkg::op_type               op_ff   [2];
   logic [ID_BITS-1:0]             id_ff   [2];
   logic [tkfl_pkg::DIST_BITS-1:0] dist_ff [2];

   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;
   tkfl_pkg::op_type op_in;

   always_comb begin
      req.ready = (fill_ff != FILL_FULL);
      q.valid   = (fill_ff != 2'd0);
      push      = req.valid && req.ready;
      pop       = q.valid && q.ready;
      op_in     = tkfl_pkg::op_type'(req.operation);
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
      q.operation = op_ff[rd_ptr_ff];
      q.cand_id   = id_ff[rd_ptr_ff];
      q.cand_dist = dist_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff]   <= op_in;
         id_ff[wr_ptr_ff]   <= req.cand_id;
         dist_ff[wr_ptr_ff] <= req.cand_dist;
      end
   end

endmodule

### rtl/tkfl_back.sv
// Back end: sorted shift list with parallel rank compare, read-out rotation and result register.
module tkfl_back #(
   parameter int MAX_K   = 16,
   parameter int ID_BITS = 24
) (
   input logic          clock,
   input logic          reset,
   tkfl_req_if.sink     q,
   tkfl_rsp_if.source   rsp,
   tkfl_csr_if.sink     csr
);

   localparam int DB = tkfl_pkg::DIST_BITS;
   localparam int KW = $clog2(MAX_K + 1);
   localparam int SW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int CW = (KW > tkfl_pkg::KCFG_BITS) ? KW : tkfl_pkg::KCFG_BITS;
   localparam int K_RST_VAL = (tkfl_pkg::K_RESET > MAX_K) ? MAX_K : tkfl_pkg::K_RESET;
   localparam logic [KW-1:0] K_RST     = KW'(K_RST_VAL);
   localparam logic [SW-1:0] STEP_LAST = SW'(MAX_K - 1);

   logic [DB-1:0]      list_dist_ff [MAX_K];
   logic [DB-1:0]      list_dist_in [MAX_K];
   logic [ID_BITS-1:0] list_id_ff   [MAX_K];
   logic [ID_BITS-1:0] list_id_in   [MAX_K];
   logic [DB-1:0]      ins_dist     [MAX_K];
   logic [ID_BITS-1:0] ins_id       [MAX_K];
   logic [MAX_K-1:0]   ge;

   tkfl_pkg::back_state_type state_ff, state_in;
   logic [KW-1:0] cnt_ff, cnt_in;
   logic [KW-1:0] k_ff, k_in;
   logic [SW-1:0] step_ff, step_in;
   logic          ovf_ff, ovf_in;

   logic               out_valid_ff, out_valid_in;
   logic               out_prune_valid_ff, out_prune_valid_in;
   logic [DB-1:0]      out_prune_dist_ff, out_prune_dist_in;
   logic               out_entry_valid_ff, out_entry_valid_in;
   logic [ID_BITS-1:0] out_entry_id_ff, out_entry_id_in;
   logic [DB-1:0]      out_entry_dist_ff, out_entry_dist_in;
   logic               out_last_ff, out_last_in;

   logic          out_free;
   logic          emit;
   logic          full;
   logic [DB-1:0] prune_sel;
   logic [CW-1:0] k_wr;

   // Each cell decides from its own compare whether the candidate lands at or above it.
   always_comb begin
      for (int j = 0; j < MAX_K; j++) begin
         ge[j] = (KW'(j) >= cnt_ff) || (q.cand_dist > list_dist_ff[j]) ||
                 ((q.cand_dist == list_dist_ff[j]) && (q.cand_id > list_id_ff[j]));
      end
      for (int j = 0; j < MAX_K; j++) begin
         if (!ge[j]) begin
            ins_dist[j] = list_dist_ff[j];
            ins_id[j]   = list_id_ff[j];
         end else if (j == 0) begin
            ins_dist[j] = q.cand_dist;
            ins_id[j]   = q.cand_id;
         end else if (!ge[j-1]) begin
            ins_dist[j] = q.cand_dist;
            ins_id[j]   = q.cand_id;
         end else begin
            ins_dist[j] = list_dist_ff[j-1];
            ins_id[j]   = list_id_ff[j-1];
         end
      end
      prune_sel = '0;
      for (int j = 0; j < MAX_K; j++) begin
         if (KW'(j) == (k_ff - KW'(1))) begin
            prune_sel = prune_sel | list_dist_ff[j];
         end
      end
   end

   always_comb begin
      state_in           = state_ff;
      cnt_in             = cnt_ff;
      k_in               = k_ff;
      step_in            = step_ff;
      ovf_in             = ovf_ff;
      list_dist_in       = list_dist_ff;
      list_id_in         = list_id_ff;
      out_free           = !out_valid_ff || rsp.ready;
      out_valid_in       = out_valid_ff && !rsp.ready;
      out_prune_valid_in = out_prune_valid_ff;
      out_prune_dist_in  = out_prune_dist_ff;
      out_entry_valid_in = out_entry_valid_ff;
      out_entry_id_in    = out_entry_id_ff;
      out_entry_dist_in  = out_entry_dist_ff;
      out_last_in        = out_last_ff;
      emit               = (KW'(step_ff) < cnt_ff);
      full               = (cnt_ff >= k_ff);
      q.ready            = (state_ff == tkfl_pkg::BK_IDLE);
      csr.ready          = 1'b1;

      case (state_ff)
         tkfl_pkg::BK_IDLE: begin
            if (q.valid) begin
               if (tkfl_pkg::op_type'(q.operation) == tkfl_pkg::OP_INSERT) begin
                  list_dist_in = ins_dist;
                  list_id_in   = ins_id;
                  ovf_in       = full;
                  cnt_in       = full ? k_ff : (cnt_ff + KW'(1));
                  state_in     = tkfl_pkg::BK_PRUNE;
               end else begin
                  step_in  = '0;
                  state_in = tkfl_pkg::BK_READ;
               end
            end
         end
         tkfl_pkg::BK_PRUNE: begin
            if (out_free) begin
               out_valid_in       = 1'b1;
               out_prune_valid_in = ovf_ff;
               out_prune_dist_in  = ovf_ff ? prune_sel : '0;
               out_entry_valid_in = 1'b0;
               out_entry_id_in    = '0;
               out_entry_dist_in  = '0;
               out_last_in        = 1'b1;
               state_in           = tkfl_pkg::BK_IDLE;
            end
         end
         tkfl_pkg::BK_READ: begin
            if (cnt_ff == '0) begin
               if (out_free) begin
                  out_valid_in       = 1'b1;
                  out_prune_valid_in = 1'b0;
                  out_prune_dist_in  = '0;
                  out_entry_valid_in = 1'b0;
                  out_entry_id_in    = '0;
                  out_entry_dist_in  = '0;
                  out_last_in        = 1'b1;
                  state_in           = tkfl_pkg::BK_IDLE;
               end
            end else if (!emit || out_free) begin
               // The whole list turns by one place per step; after MAX_K steps it is back in order.
               for (int j = 0; j < MAX_K; j++) begin
                  if (j == MAX_K - 1) begin
                     list_dist_in[j] = list_dist_ff[0];
                     list_id_in[j]   = list_id_ff[0];
                  end else begin
                     list_dist_in[j] = list_dist_ff[j+1];
                     list_id_in[j]   = list_id_ff[j+1];
                  end
               end
               if (emit) begin
                  out_valid_in       = 1'b1;
                  out_prune_valid_in = 1'b0;
                  out_prune_dist_in  = '0;
                  out_entry_valid_in = 1'b1;
                  out_entry_id_in    = list_id_ff[0];
                  out_entry_dist_in  = list_dist_ff[0];
                  out_last_in        = ((KW'(step_ff) + KW'(1)) == cnt_ff);
               end
               if (step_ff == STEP_LAST) begin
                  state_in = tkfl_pkg::BK_IDLE;
               end else begin
                  step_in = step_ff + SW'(1);
               end
            end
         end
         default: begin
            state_in = tkfl_pkg::BK_IDLE;
         end
      endcase

      // A new k only takes effect while the list is empty; zero and oversize values are clamped.
      k_wr = CW'(csr.k_count);
      if (k_wr == '0) begin
         k_wr = CW'(1);
      end else if (k_wr > CW'(MAX_K)) begin
         k_wr = CW'(MAX_K);
      end
      if (csr.valid && (cnt_ff == '0)) begin
         k_in = KW'(k_wr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tkfl_pkg::BK_IDLE;
         cnt_ff       <= '0;
         k_ff         <= K_RST;
         step_ff      <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         step_ff      <= step_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      list_dist_ff       <= list_dist_in;
      list_id_ff         <= list_id_in;
      out_prune_valid_ff <= out_prune_valid_in;
      out_prune_dist_ff  <= out_prune_dist_in;
      out_entry_valid_ff <= out_entry_valid_in;
      out_entry_id_ff    <= out_entry_id_in;
      out_entry_dist_ff  <= out_entry_dist_in;
      out_last_ff        <= out_last_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.prune_valid = out_prune_valid_ff;
   assign rsp.prune_dist  = out_prune_dist_ff;
   assign rsp.entry_valid = out_entry_valid_ff;
   assign rsp.entry_id    = out_entry_id_ff;
   assign rsp.entry_dist  = out_entry_dist_ff;
   assign rsp.last        = out_last_ff;

endmodule

### rtl/top_k_farthest_list_core.sv
// Top level of the top-k farthest list: request queue in front of the sorted list engine.
//
//   channel    direction  word
//   req_chan   in         operation, cand_id, cand_dist
//   rsp_chan   out        prune_valid, prune_dist, entry_valid, entry_id, entry_dist, last
//   csr_chan   in         k_count (always ready, taken only while the list is empty)
//
// In the list engine an insert first does the parallel compare and shift, then selects the
// rank-k bound into the result register. A read-out rotates the whole list through entry 0;
// an empty read-out gives a single last word. Reset is synchronous and needs no clearing
// pass. A two-word queue lets requests arrive while the engine works; a stalled response
// holds the engine, and the queue keeps taking requests only until it is full.
module top_k_farthest_list_core #(
   parameter int MAX_K   = 16,
   parameter int ID_BITS = 24
) (
   input logic          clock,
   input logic          reset,
   tkfl_req_if.sink     req_chan,
   tkfl_rsp_if.source   rsp_chan,
   tkfl_csr_if.sink     csr_chan
);

   tkfl_req_if #(.ID_BITS(ID_BITS)) queue_link ();

   tkfl_front #(
      .ID_BITS (ID_BITS)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .q     (queue_link)
   );

   tkfl_back #(
      .MAX_K   (MAX_K),
      .ID_BITS (ID_BITS)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .q     (queue_link),
      .rsp   (rsp_chan),
      .csr   (csr_chan)
   );

endmodule

### rtl/tkfl_checker.sv
// Port-level assertions for the top-k farthest list, bound to the top level.
`include "top_k_farthest_list_core_assert.svh"

module tkfl_checker #(
   parameter int ID_BITS = 24
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           csr_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_prune_valid,
   input logic [tkfl_pkg::DIST_BITS-1:0] rsp_prune_dist,
   input logic                           rsp_entry_valid,
   input logic [ID_BITS-1:0]             rsp_entry_id,
   input logic [tkfl_pkg::DIST_BITS-1:0] rsp_entry_dist,
   input logic                           rsp_last
);

   localparam int WORD_BITS = 3 + 2 * tkfl_pkg::DIST_BITS + ID_BITS;

   logic [WORD_BITS-1:0] word;
   logic                 stalled;
   logic                 no_entry;
   logic                 pruned;
   logic                 insert_word;

   assign word        = {rsp_prune_valid, rsp_prune_dist, rsp_entry_valid, rsp_entry_id,
                         rsp_entry_dist, rsp_last};
   assign stalled     = rsp_valid && !rsp_ready;
   assign no_entry    = rsp_valid && !rsp_entry_valid;
   assign pruned      = rsp_valid && rsp_prune_valid;
   assign insert_word = !rsp_entry_valid && rsp_last;

   `TKFL_ASSERT_RST(a_rsp_hold, clock, reset, stalled |=> rsp_valid && $stable(word), "stalled word changed")
   `TKFL_ASSERT_RST(a_single_word, clock, reset, no_entry |-> rsp_last, "entry-less word not last")
   `TKFL_ASSERT_RST(a_prune_insert, clock, reset, pruned |-> insert_word, "bound on a read-out word")
   `TKFL_ASSERT_ALL(a_reset_quiet, clock, reset |=> !rsp_valid && csr_ready, "busy after reset")

endmodule

bind top_k_farthest_list_core tkfl_checker #(
   .ID_BITS (ID_BITS)
) u_tkfl_checker (
   .clock           (clock),
   .reset           (reset),
   .csr_ready       (csr_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_prune_valid (rsp_chan.prune_valid),
   .rsp_prune_dist  (rsp_chan.prune_dist),
   .rsp_entry_valid (rsp_chan.entry_valid),
   .rsp_entry_id    (rsp_chan.entry_id),
   .rsp_entry_dist  (rsp_chan.entry_dist),
   .rsp_last        (rsp_chan.last)
);
